[rtl/oiat_pkg.sv]
// Shared types and constants for the ordered id allowlist table.
// Used by oiat_ctrl, oiat_dp and ordered_id_allowlist_table_top; no dependencies.
package oiat_pkg;

    localparam int UID_W   = 32;
    localparam int BITC_W  = 2;
    localparam int KEY_W   = 16;
    localparam int SIG_W   = 8;
    localparam int LIM_W   = 16;
    localparam int TOTAL_W = 7;
    localparam int MODE_W  = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REM_KEY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REM_SIG = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ENUM    = 3'd4;

    localparam logic CFG_DYN_EN  = 1'b0;
    localparam logic CFG_DYN_SIG = 1'b1;

    // Steps of the key reduction.
    localparam logic [BITC_W-1:0] MOD_MUL = 2'd0;
    localparam logic [BITC_W-1:0] MOD_SUB = 2'd1;
    localparam logic [BITC_W-1:0] MOD_FIX = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mod_step;
        logic scan_step;
        logic scan_end;
        logic auth_step;
        logic auth_end;
        logic emit_out;
        logic emit_skip;
        logic fin_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_last;
        logic idx_end;
        logic emit_hit;
        logic enum_mode;
        logic out_free;
    } t_status;

endpackage

[rtl/oiat_ctrl.sv]
// Sequencing state machine for the ordered id allowlist table.
// Depends on oiat_pkg for the command and status structs.
module oiat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  oiat_pkg::t_status i_st,
    output oiat_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MOD  = 6'b000010,
        S_SCAN = 6'b000100,
        S_AUTH = 6'b001000,
        S_EMIT = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_st.mod_last) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_st.idx_end) begin
                    o_cmd.scan_end = 1'b1;
                    n_state        = S_AUTH;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_AUTH: begin
                if (i_st.idx_end) begin
                    o_cmd.auth_end = 1'b1;
                    n_state        = i_st.enum_mode ? S_EMIT : S_FIN;
                end else begin
                    o_cmd.auth_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_st.idx_end) begin
                    n_state = S_FIN;
                end else if (!i_st.emit_hit) begin
                    o_cmd.emit_skip = 1'b1;
                end else if (i_st.out_free) begin
                    o_cmd.emit_out = 1'b1;
                end
            end
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.fin_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/oiat_dp.sv]
// Datapath of the ordered id allowlist table: key reduction, slot storage,
// scan passes and the output register. Depends on oiat_pkg.
module oiat_dp #(
    parameter int DEPTH         = 16,
    parameter int APPID_MODULUS = 100000,
    parameter int INVALID_ID    = 65535
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  oiat_pkg::t_cmd                    i_cmd,
    output oiat_pkg::t_status                 o_st,
    input  logic                              i_dyn_en,
    input  logic [oiat_pkg::SIG_W-1:0]        i_dyn_sig,
    input  logic [oiat_pkg::MODE_W-1:0]       i_mode,
    input  logic [oiat_pkg::UID_W-1:0]        i_user_id,
    input  logic [oiat_pkg::SIG_W-1:0]        i_sig_in,
    input  logic [oiat_pkg::LIM_W-1:0]        i_list_limit,
    input  logic                              i_stall,
    output logic                              o_valid,
    output logic                              o_found,
    output logic [oiat_pkg::SIG_W-1:0]        o_sig_out,
    output logic [oiat_pkg::KEY_W-1:0]        o_entry_key,
    output logic                              o_is_entry,
    output logic [oiat_pkg::TOTAL_W-1:0]      o_auth_count,
    output logic                              o_has_any,
    output logic [oiat_pkg::KEY_W-1:0]        o_last_manager,
    output logic                              o_full_drop,
    output logic                              o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW = $clog2(APPID_MODULUS + 1) + 1;
    localparam int QW = oiat_pkg::UID_W + 1;
    localparam int PW = QW + oiat_pkg::UID_W;
    localparam logic [RW-1:0] MODV = RW'(APPID_MODULUS);
    localparam logic [QW-1:0] RECIP = QW'((64'd1 << oiat_pkg::UID_W) / APPID_MODULUS);
    localparam logic [oiat_pkg::KEY_W-1:0] INV = oiat_pkg::KEY_W'(INVALID_ID);

    logic [oiat_pkg::KEY_W-1:0] r_slot_key [DEPTH];
    logic [oiat_pkg::SIG_W-1:0] r_slot_sig [DEPTH];

    logic [oiat_pkg::MODE_W-1:0] r_mode;
    logic [oiat_pkg::UID_W-1:0]  r_uid;
    logic [oiat_pkg::SIG_W-1:0]  r_sig_in;
    logic [oiat_pkg::LIM_W-1:0]  r_limit;
    logic [oiat_pkg::BITC_W-1:0] r_bitc;
    logic [RW-1:0]               r_q;
    logic [RW-1:0]               r_rem;
    logic [CW-1:0]               r_cnt, r_idx, r_wr, r_emitted;
    logic [oiat_pkg::KEY_W-1:0]  r_last, r_survivor;
    logic                        r_present, r_hit_last, r_found, r_full;
    logic [oiat_pkg::SIG_W-1:0]  r_fsig;
    logic [oiat_pkg::TOTAL_W-1:0] r_total;

    logic [PW-1:0]               w_prod;
    logic [RW-1:0]               n_rem;
    logic [RW+oiat_pkg::KEY_W-1:0] w_rem_ext;
    logic [oiat_pkg::KEY_W-1:0]  w_key, w_cur_key;
    logic [oiat_pkg::SIG_W-1:0]  w_cur_sig;
    logic                        w_cur_auth, w_rem_match, w_is_rem;

    // The reciprocal product gives a quotient that is exact or one short, so
    // the remainder taken from its low bits needs at most one correction.
    assign w_prod    = PW'(r_uid) * PW'(RECIP);
    assign n_rem     = (r_rem >= MODV) ? (r_rem - MODV) : r_rem;
    assign w_rem_ext = {{oiat_pkg::KEY_W{1'b0}}, r_rem};
    assign w_key     = w_rem_ext[oiat_pkg::KEY_W-1:0];

    assign w_cur_key  = r_slot_key[r_idx[IW-1:0]];
    assign w_cur_sig  = r_slot_sig[r_idx[IW-1:0]];
    assign w_cur_auth = (w_cur_sig != i_dyn_sig) || i_dyn_en;
    assign w_is_rem   = (r_mode == oiat_pkg::MODE_REM_KEY) || (r_mode == oiat_pkg::MODE_REM_SIG);
    assign w_rem_match = (r_mode == oiat_pkg::MODE_REM_SIG) ? (w_cur_sig == r_sig_in)
                                                            : (w_cur_key == w_key);

    assign o_st.mod_last  = (r_bitc == oiat_pkg::MOD_FIX);
    assign o_st.idx_end   = (r_idx == r_cnt);
    assign o_st.emit_hit  = w_cur_auth && (oiat_pkg::LIM_W'(r_emitted) < r_limit);
    assign o_st.enum_mode = (r_mode == oiat_pkg::MODE_ENUM);
    assign o_st.out_free  = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_uid      <= i_user_id;
            r_sig_in   <= i_sig_in;
            r_limit    <= i_list_limit;
            r_bitc     <= '0;
            r_q        <= '0;
            r_rem      <= '0;
            r_idx      <= '0;
            r_wr       <= '0;
            r_emitted  <= '0;
            r_present  <= 1'b0;
            r_hit_last <= 1'b0;
            r_survivor <= INV;
            r_found    <= 1'b0;
            r_fsig     <= '0;
            r_full     <= 1'b0;
            r_total    <= '0;
        end
        if (i_cmd.mod_step) begin
            r_bitc <= r_bitc + 1'b1;
            case (r_bitc)
                oiat_pkg::MOD_MUL: r_q   <= w_prod[oiat_pkg::UID_W +: RW];
                oiat_pkg::MOD_SUB: r_rem <= r_uid[RW-1:0] - r_q * MODV;
                default:           r_rem <= n_rem;
            endcase
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + 1'b1;
            if (r_mode == oiat_pkg::MODE_INSERT && w_cur_key == w_key) begin
                r_present <= 1'b1;
            end
            if (r_mode == oiat_pkg::MODE_LOOKUP && !r_found && w_cur_key == w_key
                && w_cur_auth) begin
                r_found <= 1'b1;
                r_fsig  <= w_cur_sig;
            end
            if (w_is_rem) begin
                if (w_rem_match) begin
                    if (w_cur_key == r_last) r_hit_last <= 1'b1;
                end else begin
                    r_survivor                <= w_cur_key;
                    r_slot_key[r_wr[IW-1:0]] <= w_cur_key;
                    r_slot_sig[r_wr[IW-1:0]] <= w_cur_sig;
                    r_wr                      <= r_wr + 1'b1;
                end
            end
        end
        if (i_cmd.scan_end) begin
            r_idx <= '0;
            if (r_mode == oiat_pkg::MODE_INSERT && !r_present) begin
                if (r_cnt == CW'(DEPTH)) begin
                    r_full <= 1'b1;
                end else begin
                    r_slot_key[r_cnt[IW-1:0]] <= w_key;
                    r_slot_sig[r_cnt[IW-1:0]] <= r_sig_in;
                end
            end
        end
        if (i_cmd.auth_step) begin
            r_idx <= r_idx + 1'b1;
            if (w_cur_auth) r_total <= r_total + 1'b1;
        end
        if (i_cmd.auth_end) begin
            r_idx <= '0;
        end
        if (i_cmd.emit_skip) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.emit_out) begin
            r_idx     <= r_idx + 1'b1;
            r_emitted <= r_emitted + 1'b1;
        end
    end

    // Fill count and last-manager key are control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_last <= INV;
        end else if (i_cmd.scan_end) begin
            if (w_is_rem) begin
                r_cnt <= r_wr;
                if (r_hit_last) r_last <= r_survivor;
            end else if (r_mode == oiat_pkg::MODE_INSERT && !r_present
                         && r_cnt != CW'(DEPTH)) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_last == INV) r_last <= w_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit_out || i_cmd.fin_out) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_out) begin
            o_found        <= 1'b0;
            o_sig_out      <= w_cur_sig;
            o_entry_key    <= w_cur_key;
            o_is_entry     <= 1'b1;
            o_auth_count   <= '0;
            o_has_any      <= (r_total != '0);
            o_last_manager <= r_last;
            o_full_drop    <= 1'b0;
            o_last         <= 1'b0;
        end else if (i_cmd.fin_out) begin
            o_found        <= r_found;
            o_sig_out      <= r_fsig;
            o_entry_key    <= '0;
            o_is_entry     <= 1'b0;
            o_auth_count   <= (r_mode == oiat_pkg::MODE_ENUM) ? r_total : '0;
            o_has_any      <= (r_total != '0);
            o_last_manager <= r_last;
            o_full_drop    <= r_full;
            o_last         <= 1'b1;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("fill count above depth");
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_step |-> r_wr <= r_idx) else $error("compaction write ahead of read");
    a_emit_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_out |-> (oiat_pkg::TOTAL_W'(r_emitted) < r_total))
        else $error("more entries emitted than counted");
    a_entry_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_entry |-> !o_last) else $error("entry word marked last");

endmodule

[rtl/ordered_id_allowlist_table_top.sv]
// Top level of the ordered id allowlist table: configuration registers,
// controller and datapath. Depends on oiat_pkg, oiat_ctrl and oiat_dp.
//
// Usage:
// The input channel (i_valid / o_stall) takes one command word: mode, user id,
// signature and list limit. The output channel (o_valid / i_stall) returns the
// result words of that command; the final word of each command has o_last set.
// Enumerate returns one word per authorized entry (up to the list limit) and
// then a summary word; every other mode returns a single word.
// Configuration writes (i_cfg_valid / o_cfg_ready) set the dynamic enable bit
// (index 0) and the dynamic signature index (index 1); ready is always high.
// Operation: the key is reduced modulo APPID_MODULUS (reciprocal multiply,
// multiply-subtract, one correction), then the stored entries are passed
// through by the operation scan, then by the authorization count and, for
// enumerate, by the emit pass. The next command is accepted once the final
// word has been loaded into the output register; one command is worked on
// at a time.
// Reset empties the table, clears the last-manager key to INVALID_ID, sets the
// dynamic signature index to 1 and dynamic mode off. A stalled receiver holds
// the output word; the block waits before loading the next one.
module ordered_id_allowlist_table_top #(
    parameter int DEPTH         = 16,
    parameter int APPID_MODULUS = 100000,
    parameter int INVALID_ID    = 65535
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [oiat_pkg::MODE_W-1:0]  i_mode,
    input  logic [oiat_pkg::UID_W-1:0]   i_user_id,
    input  logic [oiat_pkg::SIG_W-1:0]   i_sig_in,
    input  logic [oiat_pkg::LIM_W-1:0]   i_list_limit,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_found,
    output logic [oiat_pkg::SIG_W-1:0]   o_sig_out,
    output logic [oiat_pkg::KEY_W-1:0]   o_entry_key,
    output logic                         o_is_entry,
    output logic [oiat_pkg::TOTAL_W-1:0] o_auth_count,
    output logic                         o_has_any,
    output logic [oiat_pkg::KEY_W-1:0]   o_last_manager,
    output logic                         o_full_drop,
    output logic                         o_last,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [oiat_pkg::SIG_W-1:0]   i_cfg_data
);

    oiat_pkg::t_cmd    w_cmd;
    oiat_pkg::t_status w_st;

    logic                       r_dyn_en;
    logic [oiat_pkg::SIG_W-1:0] r_dyn_sig;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn_en  <= 1'b0;
            r_dyn_sig <= oiat_pkg::SIG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                oiat_pkg::CFG_DYN_EN:  r_dyn_en  <= i_cfg_data[0];
                oiat_pkg::CFG_DYN_SIG: r_dyn_sig <= i_cfg_data;
                default: ;
            endcase
        end
    end

    oiat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    oiat_dp #(
        .DEPTH         (DEPTH),
        .APPID_MODULUS (APPID_MODULUS),
        .INVALID_ID    (INVALID_ID)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_dyn_en       (r_dyn_en),
        .i_dyn_sig      (r_dyn_sig),
        .i_mode         (i_mode),
        .i_user_id      (i_user_id),
        .i_sig_in       (i_sig_in),
        .i_list_limit   (i_list_limit),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_sig_out      (o_sig_out),
        .o_entry_key    (o_entry_key),
        .o_is_entry     (o_is_entry),
        .o_auth_count   (o_auth_count),
        .o_has_any      (o_has_any),
        .o_last_manager (o_last_manager),
        .o_full_drop    (o_full_drop),
        .o_last         (o_last)
    );

endmodule
